[design/gclp_pkg.sv]
package gclp_pkg;

   localparam int COORD_WIDTH_DEF     = 32;
   localparam int FRACTION_DIGITS_DEF = 4;

   // ASCII codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_PLUS   = 8'h2b;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_POINT  = 8'h2e;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SEMI   = 8'h3b;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7a;
   localparam logic [7:0] CHAR_UP_G   = 8'h47;
   localparam logic [7:0] CHAR_UP_X   = 8'h58;
   localparam logic [7:0] CHAR_UP_Y   = 8'h59;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // result status
   localparam logic [1:0] ST_MOVE  = 2'd0;
   localparam logic [1:0] ST_SKIP  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_EXPECTED_WORD = 3'd1;
   localparam logic [2:0] ERR_MISSING_VALUE = 3'd2;
   localparam logic [2:0] ERR_INVALID_VALUE = 3'd3;
   localparam logic [2:0] ERR_INVALID_G     = 3'd4;

   // supported G numbers
   localparam logic [6:0] G_RAPID  = 7'd0;
   localparam logic [6:0] G_LINEAR = 7'd1;
   localparam logic [6:0] G_INCH   = 7'd20;
   localparam logic [6:0] G_MM     = 7'd21;
   localparam logic [6:0] G_ABS    = 7'd90;
   localparam logic [6:0] G_REL    = 7'd91;
   localparam logic [10:0] G_SMALL_MAX = 11'd127;

   typedef enum logic [2:0] {
      PH_BETWEEN = 3'd0,
      PH_COMMENT = 3'd1,
      PH_REST    = 3'd2,
      PH_SPACE   = 3'd3,
      PH_NUMBER  = 3'd4,
      PH_ERROR   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_G     = 2'd1,
      KIND_X     = 2'd2,
      KIND_Y     = 2'd3
   } kind_type;

   typedef struct packed {
      logic       is_nul;
      logic       is_ws;
      logic       is_digit;
      logic       is_letter;
      logic       is_semi;
      logic       is_lparen;
      logic       is_rparen;
      logic       is_point;
      logic       is_plus;
      logic       is_minus;
      logic [3:0] digit;
      kind_type   kind;
   } char_class_type;

   typedef struct packed {
      logic unsup;
      logic y;
      logic x;
      logic move;
   } line_flags_type;

endpackage

[design/gcode_line_move_parser.sv]
// A character word is registered in the input register on acceptance and parsed from there;
//   the result of a terminating NUL is then registered in the output register.
// Throughput: one character per cycle; the parse step is one register-to-register pass.
//   A NUL waits only while the output register is full and stalled.
// Reset (synchronous): parser between words, position 0/0, absolute millimetre mode.
module gcode_line_move_parser import gclp_pkg::*; #(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [2:0]                    rsp_error_code,
   output logic signed [COORD_WIDTH-1:0] rsp_target_x,
   output logic signed [COORD_WIDTH-1:0] rsp_target_y
);

   // input register: one character word
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;

   // output register: one result word
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_status_ff, out_status_in;
   logic [2:0]             out_err_ff, out_err_in;
   logic [COORD_WIDTH-1:0] out_x_ff, out_x_in;
   logic [COORD_WIDTH-1:0] out_y_ff, out_y_in;

   logic                   req_take;
   logic                   out_room;
   logic                   step_en;
   logic                   res_valid;
   logic [1:0]             res_status;
   logic [2:0]             res_error_code;
   logic [COORD_WIDTH-1:0] res_target_x;
   logic [COORD_WIDTH-1:0] res_target_y;

   // Ordinary characters never wait on the result side; only a NUL,
   // which produces a result word, needs room in the output register.
   assign out_room  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && ((in_char_ff != CHAR_NUL) || out_room);
   assign req_stall = in_valid_ff && !step_en;
   assign req_take  = req_valid && !req_stall;

   gclp_parser #(
      .COORD_WIDTH     (COORD_WIDTH),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .char_code      (in_char_ff),
      .res_valid      (res_valid),
      .res_status     (res_status),
      .res_error_code (res_error_code),
      .res_target_x   (res_target_x),
      .res_target_y   (res_target_y)
   );

   always_comb begin
      in_valid_in   = req_take || (in_valid_ff && !step_en);
      in_char_in    = req_take ? req_char_code : in_char_ff;
      out_valid_in  = res_valid || (out_valid_ff && rsp_stall);
      out_status_in = res_valid ? res_status : out_status_ff;
      out_err_in    = res_valid ? res_error_code : out_err_ff;
      out_x_in      = res_valid ? res_target_x : out_x_ff;
      out_y_in      = res_valid ? res_target_y : out_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      out_status_ff <= out_status_in;
      out_err_ff    <= out_err_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_error_code = out_err_ff;
   assign rsp_target_x   = $signed(out_x_ff);
   assign rsp_target_y   = $signed(out_y_ff);

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_room)
      else $error("result produced while output register blocked");

   // a held character is not dropped
   a_char_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_char_ff))
      else $error("stalled character lost");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MOVE || rsp_status == ST_SKIP) |->
         rsp_error_code == ERR_NONE)
      else $error("error code on non-error line");

endmodule

[design/gclp_char_class.sv]
module gclp_char_class import gclp_pkg::*; (
   input  logic [7:0]     char_code,
   output char_class_type cls
);

   logic       is_upper;
   logic       is_lower;
   logic [7:0] upper;
   logic [7:0] digit_full;

   always_comb begin
      is_upper   = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_Z);
      is_lower   = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_Z);
      upper      = is_lower ? (char_code - CASE_OFFSET) : char_code;
      digit_full = char_code - CHAR_ZERO;

      cls           = '0;
      cls.is_nul    = (char_code == CHAR_NUL);
      cls.is_ws     = (char_code == CHAR_SPACE) ||
                      ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
      cls.is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      cls.is_letter = is_upper || is_lower;
      cls.is_semi   = (char_code == CHAR_SEMI);
      cls.is_lparen = (char_code == CHAR_LPAREN);
      cls.is_rparen = (char_code == CHAR_RPAREN);
      cls.is_point  = (char_code == CHAR_POINT);
      cls.is_plus   = (char_code == CHAR_PLUS);
      cls.is_minus  = (char_code == CHAR_MINUS);
      cls.digit     = digit_full[3:0];
      if (upper == CHAR_UP_G) begin
         cls.kind = KIND_G;
      end else if (upper == CHAR_UP_X) begin
         cls.kind = KIND_X;
      end else if (upper == CHAR_UP_Y) begin
         cls.kind = KIND_Y;
      end else begin
         cls.kind = KIND_OTHER;
      end
   end

endmodule

[design/gclp_parser.sv]
module gclp_parser import gclp_pkg::*; #(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             char_code,
   output logic                   res_valid,
   output logic [1:0]             res_status,
   output logic [2:0]             res_error_code,
   output logic [COORD_WIDTH-1:0] res_target_x,
   output logic [COORD_WIDTH-1:0] res_target_y
);

   localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);
   localparam int NEXT_W = ((COORD_WIDTH + 3 > 24) ? COORD_WIDTH + 3 : 24) + 1;
   localparam logic [NEXT_W-1:0] MAG_LIMIT = NEXT_W'(1) << (COORD_WIDTH - 1);
   localparam logic [COORD_WIDTH-1:0] LIMIT_W = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   function automatic logic [NEXT_W-1:0] pow10(input int n);
      logic [NEXT_W-1:0] p;
      p = NEXT_W'(1);
      for (int i = 0; i < n; i++) begin
         p = p * NEXT_W'(10);
      end
      return p;
   endfunction

   char_class_type cls;

   gclp_char_class u_class (
      .char_code (char_code),
      .cls       (cls)
   );

   // place value of one digit, by position below the integer point
   logic [NEXT_W-1:0] place_tab [FRACTION_DIGITS + 1];
   for (genvar gi = 0; gi <= FRACTION_DIGITS; gi++) begin : g_place
      assign place_tab[gi] = pow10(gi);
   end

   // parse state
   phase_type              phase_ff, phase_in;
   kind_type               kind_ff, kind_in;
   logic                   neg_ff, neg_in;
   logic [COORD_WIDTH-1:0] scaled_ff, scaled_in;
   logic                   ovf_ff, ovf_in;
   logic [CNT_W-1:0]       fd_ff, fd_in;
   logic                   point_ff, point_in;
   logic                   digit_ff, digit_in;
   logic [6:0]             gint_ff, gint_in;
   logic                   gbig_ff, gbig_in;
   logic                   fracnz_ff, fracnz_in;
   line_flags_type         flags_ff, flags_in;
   logic [2:0]             err_ff, err_in;
   logic [COORD_WIDTH-1:0] pend_x_ff, pend_x_in;
   logic [COORD_WIDTH-1:0] pend_y_ff, pend_y_in;
   logic [COORD_WIDTH-1:0] pos_x_ff, pos_x_in;
   logic [COORD_WIDTH-1:0] pos_y_ff, pos_y_in;
   logic                   abs_ff, abs_in;
   logic                   mm_ff, mm_in;

   // number update
   logic                   num_start;
   logic                   b_neg, b_ovf, b_point, b_digit, b_gbig, b_fracnz;
   logic [COORD_WIDTH-1:0] b_scaled;
   logic [CNT_W-1:0]       b_fd;
   logic [6:0]             b_gint;
   logic                   frac_room;
   logic [CNT_W-1:0]       place_idx;
   logic [NEXT_W-1:0]      acc_ext;
   logic [NEXT_W-1:0]      term;
   logic [NEXT_W-1:0]      push_sum;
   logic [10:0]            gprod;
   logic                   n_neg, n_ovf, n_point, n_digit, n_gbig, n_fracnz;
   logic [COORD_WIDTH-1:0] n_scaled;
   logic [CNT_W-1:0]       n_fd;
   logic [6:0]             n_gint;

   always_comb begin
      num_start = (phase_ff == PH_SPACE);
      b_neg     = num_start ? 1'b0 : neg_ff;
      b_scaled  = num_start ? '0 : scaled_ff;
      b_ovf     = num_start ? 1'b0 : ovf_ff;
      b_fd      = num_start ? '0 : fd_ff;
      b_point   = num_start ? 1'b0 : point_ff;
      b_digit   = num_start ? 1'b0 : digit_ff;
      b_gint    = num_start ? '0 : gint_ff;
      b_gbig    = num_start ? 1'b0 : gbig_ff;
      b_fracnz  = num_start ? 1'b0 : fracnz_ff;

      frac_room = (b_fd < CNT_W'(FRACTION_DIGITS));
      place_idx = (b_point && frac_room) ? (CNT_W'(FRACTION_DIGITS - 1) - b_fd)
                                         : CNT_W'(FRACTION_DIGITS);
      acc_ext   = NEXT_W'(b_scaled);
      term      = place_tab[place_idx] * NEXT_W'(cls.digit);
      // integer digit: value*10 + d*unit; kept fraction digit: value + d*place
      push_sum  = (b_point ? acc_ext : ((acc_ext << 3) + (acc_ext << 1))) + term;
      gprod     = (11'(b_gint) << 3) + (11'(b_gint) << 1) + 11'(cls.digit);

      n_neg    = b_neg;
      n_scaled = b_scaled;
      n_ovf    = b_ovf;
      n_fd     = b_fd;
      n_point  = b_point;
      n_digit  = b_digit;
      n_gint   = b_gint;
      n_gbig   = b_gbig;
      n_fracnz = b_fracnz;

      if (cls.is_plus || cls.is_minus) begin
         n_neg = cls.is_minus;
      end
      if (cls.is_digit) begin
         n_digit = 1'b1;
         if ((!b_point || frac_room) && !b_ovf) begin
            if (push_sum > MAG_LIMIT) begin
               n_ovf = 1'b1;
            end else begin
               n_scaled = push_sum[COORD_WIDTH-1:0];
            end
         end
         if (!b_point) begin
            if (b_gbig || (gprod > G_SMALL_MAX)) begin
               n_gbig = 1'b1;
            end else begin
               n_gint = gprod[6:0];
            end
         end else if (frac_room) begin
            n_fd = b_fd + CNT_W'(1);
            if (cls.digit != 4'd0) begin
               n_fracnz = 1'b1;
            end
         end
      end
      if (cls.is_point) begin
         n_point = 1'b1;
      end
   end

   // end of the current number, evaluated on the stored state
   logic                   fin_ovf;
   logic                   fin_ok;
   logic [2:0]             fin_err;
   line_flags_type         fin_flags;
   logic                   fin_mm_wr, fin_mm_val, fin_abs_wr, fin_abs_val;
   logic [COORD_WIDTH-1:0] fin_value;

   always_comb begin
      fin_ovf     = ovf_ff || (!neg_ff && (scaled_ff == LIMIT_W));
      fin_ok      = 1'b0;
      fin_err     = ERR_NONE;
      fin_flags   = '0;
      fin_mm_wr   = 1'b0;
      fin_mm_val  = 1'b0;
      fin_abs_wr  = 1'b0;
      fin_abs_val = 1'b0;
      fin_value   = neg_ff ? (COORD_WIDTH'(0) - scaled_ff) : scaled_ff;

      if (!digit_ff) begin
         fin_err = (kind_ff != KIND_OTHER) ? ERR_MISSING_VALUE : ERR_EXPECTED_WORD;
      end else if (kind_ff == KIND_OTHER) begin
         fin_ok = 1'b1;
      end else if (fin_ovf) begin
         fin_err = ERR_INVALID_VALUE;
      end else if (kind_ff == KIND_G) begin
         if (fracnz_ff) begin
            fin_err = ERR_INVALID_G;
         end else begin
            fin_ok = 1'b1;
            if (gbig_ff || (neg_ff && (gint_ff != G_RAPID))) begin
               fin_flags.unsup = 1'b1;
            end else begin
               unique case (gint_ff) inside
                  G_RAPID, G_LINEAR: fin_flags.move = 1'b1;
                  G_INCH: begin
                     fin_mm_wr  = 1'b1;
                     fin_mm_val = 1'b0;
                  end
                  G_MM: begin
                     fin_mm_wr  = 1'b1;
                     fin_mm_val = 1'b1;
                  end
                  G_ABS: begin
                     fin_abs_wr  = 1'b1;
                     fin_abs_val = 1'b1;
                  end
                  G_REL: begin
                     fin_abs_wr  = 1'b1;
                     fin_abs_val = 1'b0;
                  end
                  default: fin_flags.unsup = 1'b1;
               endcase
            end
         end
      end else begin
         fin_ok      = 1'b1;
         fin_flags.x = (kind_ff == KIND_X);
         fin_flags.y = (kind_ff == KIND_Y);
      end
   end

   // character at a word boundary
   phase_type btw_phase;
   logic      btw_fail;

   always_comb begin
      btw_fail = 1'b0;
      if (cls.is_ws) begin
         btw_phase = PH_BETWEEN;
      end else if (cls.is_semi) begin
         btw_phase = PH_REST;
      end else if (cls.is_lparen) begin
         btw_phase = PH_COMMENT;
      end else if (!cls.is_letter) begin
         btw_phase = PH_ERROR;
         btw_fail  = 1'b1;
      end else begin
         btw_phase = PH_SPACE;
      end
   end

   logic do_finish;
   logic do_between;
   logic line_move;

   always_comb begin
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      neg_in         = neg_ff;
      scaled_in      = scaled_ff;
      ovf_in         = ovf_ff;
      fd_in          = fd_ff;
      point_in       = point_ff;
      digit_in       = digit_ff;
      gint_in        = gint_ff;
      gbig_in        = gbig_ff;
      fracnz_in      = fracnz_ff;
      flags_in       = flags_ff;
      err_in         = err_ff;
      pend_x_in      = pend_x_ff;
      pend_y_in      = pend_y_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      abs_in         = abs_ff;
      mm_in          = mm_ff;
      do_finish      = 1'b0;
      do_between     = 1'b0;
      line_move      = 1'b0;
      res_valid      = 1'b0;
      res_status     = ST_SKIP;
      res_error_code = ERR_NONE;

      if (step_en) begin
         if (cls.is_nul) begin
            if (phase_ff == PH_NUMBER) begin
               do_finish = 1'b1;
            end else if ((phase_ff == PH_SPACE) && (kind_ff != KIND_OTHER)) begin
               phase_in = PH_ERROR;
               err_in   = ERR_MISSING_VALUE;
            end
         end else begin
            case (phase_ff)
               PH_BETWEEN: do_between = 1'b1;
               PH_COMMENT: begin
                  if (cls.is_rparen) begin
                     phase_in = PH_BETWEEN;
                  end
               end
               PH_SPACE: begin
                  if (cls.is_ws) begin
                     phase_in = PH_SPACE;
                  end else if (cls.is_digit || cls.is_point || cls.is_plus ||
                               cls.is_minus) begin
                     phase_in = PH_NUMBER;
                     neg_in    = n_neg;
                     scaled_in = n_scaled;
                     ovf_in    = n_ovf;
                     fd_in     = n_fd;
                     point_in  = n_point;
                     digit_in  = n_digit;
                     gint_in   = n_gint;
                     gbig_in   = n_gbig;
                     fracnz_in = n_fracnz;
                  end else if (kind_ff != KIND_OTHER) begin
                     phase_in = PH_ERROR;
                     err_in   = ERR_MISSING_VALUE;
                  end else begin
                     do_between = 1'b1;
                  end
               end
               PH_NUMBER: begin
                  if (cls.is_digit || (cls.is_point && !point_ff)) begin
                     scaled_in = n_scaled;
                     ovf_in    = n_ovf;
                     fd_in     = n_fd;
                     point_in  = n_point;
                     digit_in  = n_digit;
                     gint_in   = n_gint;
                     gbig_in   = n_gbig;
                     fracnz_in = n_fracnz;
                  end else begin
                     do_finish  = 1'b1;
                     do_between = fin_ok;
                  end
               end
               default: ;
            endcase
         end

         if (do_finish) begin
            if (!fin_ok) begin
               phase_in = PH_ERROR;
               err_in   = fin_err;
            end else begin
               phase_in = PH_BETWEEN;
               flags_in = flags_ff | fin_flags;
               if (fin_flags.x) begin
                  pend_x_in = fin_value;
               end
               if (fin_flags.y) begin
                  pend_y_in = fin_value;
               end
               if (fin_mm_wr) begin
                  mm_in = fin_mm_val;
               end
               if (fin_abs_wr) begin
                  abs_in = fin_abs_val;
               end
            end
         end

         if (do_between) begin
            phase_in = btw_phase;
            if (btw_fail) begin
               err_in = ERR_EXPECTED_WORD;
            end
            if (cls.is_letter) begin
               kind_in = cls.kind;
            end
         end

         // line end: decide, commit position, clear line state
         if (cls.is_nul) begin
            res_valid = 1'b1;
            line_move = !flags_in.unsup && flags_in.move && (flags_in.x || flags_in.y) &&
                        abs_in && mm_in;
            if (phase_in == PH_ERROR) begin
               res_status     = ST_ERROR;
               res_error_code = err_in;
            end else if (line_move) begin
               res_status = ST_MOVE;
               if (flags_in.x) begin
                  pos_x_in = pend_x_in;
               end
               if (flags_in.y) begin
                  pos_y_in = pend_y_in;
               end
            end
            phase_in  = PH_BETWEEN;
            kind_in   = KIND_OTHER;
            flags_in  = '0;
            err_in    = ERR_NONE;
            neg_in    = 1'b0;
            scaled_in = '0;
            ovf_in    = 1'b0;
            fd_in     = '0;
            point_in  = 1'b0;
            digit_in  = 1'b0;
            gint_in   = '0;
            gbig_in   = 1'b0;
            fracnz_in = 1'b0;
         end
      end

      res_target_x = pos_x_in;
      res_target_y = pos_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BETWEEN;
         kind_ff   <= KIND_OTHER;
         neg_ff    <= 1'b0;
         scaled_ff <= '0;
         ovf_ff    <= 1'b0;
         fd_ff     <= '0;
         point_ff  <= 1'b0;
         digit_ff  <= 1'b0;
         gint_ff   <= '0;
         gbig_ff   <= 1'b0;
         fracnz_ff <= 1'b0;
         flags_ff  <= '0;
         err_ff    <= ERR_NONE;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         abs_ff    <= 1'b1;
         mm_ff     <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         neg_ff    <= neg_in;
         scaled_ff <= scaled_in;
         ovf_ff    <= ovf_in;
         fd_ff     <= fd_in;
         point_ff  <= point_in;
         digit_ff  <= digit_in;
         gint_ff   <= gint_in;
         gbig_ff   <= gbig_in;
         fracnz_ff <= fracnz_in;
         flags_ff  <= flags_in;
         err_ff    <= err_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         abs_ff    <= abs_in;
         mm_ff     <= mm_in;
      end
   end

   // pending target only matters once a flag marks it written
   always_ff @(posedge clock) begin
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
   end

   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> err_ff != ERR_NONE)
      else $error("error phase without error code");

   a_number_bounded: assert property (@(posedge clock) disable iff (reset)
      !ovf_ff && phase_ff == PH_NUMBER |-> scaled_ff <= LIMIT_W)
      else $error("number magnitude above limit without overflow");

endmodule

[tb/tb_gcode_line_move_parser.sv]
module tb_gcode_line_move_parser;
   import gclp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = COORD_WIDTH_DEF;
   localparam int FD          = FRACTION_DIGITS_DEF;
   localparam int HALF_PERIOD = 5;
   localparam int N_DIRECTED  = 28;
   // magnitude bound of a signed coordinate, and one whole mm in fixed point
   localparam logic [63:0] MAG_LIMIT = 64'd1 << (CW - 1);
   localparam logic [63:0] UNIT      = 10 ** FD;

   // one finished line as it leaves the block
   typedef struct packed {
      logic [1:0]    status;
      logic [2:0]    err;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
   } line_outcome_t;

   // directed row: line text, and a hand-written outcome where typed is set
   typedef struct {
      string         text;
      bit            typed;
      line_outcome_t outcome;
   } directed_row_t;

   typedef struct packed {
      bit            typed;
      line_outcome_t outcome;
   } hand_check_t;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_char_code = CHAR_NUL;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [1:0]           rsp_status;
   logic [2:0]           rsp_error_code;
   logic signed [CW-1:0] rsp_target_x;
   logic signed [CW-1:0] rsp_target_y;

   int tx_idle_pct = 9;
   int rx_idle_pct = 49;
   int mismatches  = 0;

   line_outcome_t line_outcome_q[$];   // lines accepted, result word not yet seen
   hand_check_t   hand_checked_q[$];   // one entry per directed line, in send order
   logic [7:0]    line_buf[$];         // random line under construction
   directed_row_t directed [N_DIRECTED];

   // ---------------------------------------------------------------------
   // Parser predictor state; declaration values are the post-reset state.
   // ---------------------------------------------------------------------
   phase_type      p_phase  = PH_BETWEEN;
   kind_type       p_kind   = KIND_OTHER;
   bit             p_neg    = 1'b0;
   logic [63:0]    p_accum  = '0;
   bit             p_ovf    = 1'b0;
   int             p_frac   = 0;
   bit             p_point  = 1'b0;
   bit             p_digit  = 1'b0;
   line_flags_type p_flags  = '0;
   logic [2:0]     p_err    = ERR_NONE;
   logic [CW-1:0]  p_pend_x = '0;
   logic [CW-1:0]  p_pend_y = '0;
   logic [CW-1:0]  p_pos_x  = '0;
   logic [CW-1:0]  p_pos_y  = '0;
   bit             p_abs    = 1'b1;
   bit             p_mm     = 1'b1;

   gcode_line_move_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_error_code (rsp_error_code),
      .rsp_target_x   (rsp_target_x),
      .rsp_target_y   (rsp_target_y)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor helpers
   // ---------------------------------------------------------------------
   function bit is_ws(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function bit is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   // error sticks until the terminating NUL
   function void flag_error(input logic [2:0] code);
      p_phase = PH_ERROR;
      p_err   = code;
   endfunction

   function void clear_number();
      p_neg   = 1'b0;
      p_accum = '0;
      p_ovf   = 1'b0;
      p_frac  = 0;
      p_point = 1'b0;
      p_digit = 1'b0;
   endfunction

   // true when c extends the number; digits past FD fraction places drop
   function bit number_char(input logic [7:0] c);
      logic [63:0] n;
      if (is_digit(c)) begin
         p_digit = 1'b1;
         if (!p_point || p_frac < FD) begin
            if (!p_ovf) begin
               n = p_accum * 10 + 64'(c - CHAR_ZERO);
               if (n > MAG_LIMIT) p_ovf = 1'b1;
               else p_accum = n;
            end
            if (p_point) p_frac++;
         end
         return 1'b1;
      end
      if (c == CHAR_POINT && !p_point) begin
         p_point = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // close the running number: scale to fixed point, then act on the word
   function void finish_number();
      logic [63:0]   mag;
      logic [63:0]   cmd;
      logic [CW-1:0] val;
      int            i;
      if (!p_digit) begin
         flag_error(p_kind != KIND_OTHER ? ERR_MISSING_VALUE : ERR_EXPECTED_WORD);
         return;
      end
      p_phase = PH_BETWEEN;
      if (p_kind == KIND_OTHER) return;
      mag = p_accum;
      for (i = p_frac; i < FD; i++) begin
         if (mag > MAG_LIMIT / 10) p_ovf = 1'b1;
         else mag = mag * 10;
      end
      if (!p_neg && mag >= MAG_LIMIT) p_ovf = 1'b1;
      if (p_ovf) begin
         flag_error(ERR_INVALID_VALUE);
         return;
      end
      if (p_kind == KIND_G) begin
         if (mag % UNIT != 0) begin
            flag_error(ERR_INVALID_G);
            return;
         end
         cmd = mag / UNIT;
         // modes change at once, even if the line fails later
         if (p_neg && cmd != 0) p_flags.unsup = 1'b1;
         else if (cmd == G_RAPID || cmd == G_LINEAR) p_flags.move = 1'b1;
         else if (cmd == G_INCH) p_mm = 1'b0;
         else if (cmd == G_MM) p_mm = 1'b1;
         else if (cmd == G_ABS) p_abs = 1'b1;
         else if (cmd == G_REL) p_abs = 1'b0;
         else p_flags.unsup = 1'b1;
         return;
      end
      val = mag[CW-1:0];
      if (p_neg) val = -val;
      if (p_kind == KIND_X) begin
         p_pend_x    = val;
         p_flags.x   = 1'b1;
      end else begin
         p_pend_y    = val;
         p_flags.y   = 1'b1;
      end
   endfunction

   // a character where a new word may start
   function void between(input logic [7:0] c);
      logic [7:0] u;
      if (is_ws(c)) return;
      if (c == CHAR_SEMI) begin
         p_phase = PH_REST;
      end else if (c == CHAR_LPAREN) begin
         p_phase = PH_COMMENT;
      end else if (!((c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
                     (c >= CHAR_LO_A && c <= CHAR_LO_Z))) begin
         flag_error(ERR_EXPECTED_WORD);
      end else begin
         u = (c >= CHAR_LO_A) ? c - CASE_OFFSET : c;
         p_kind = (u == CHAR_UP_G) ? KIND_G :
                  (u == CHAR_UP_X) ? KIND_X :
                  (u == CHAR_UP_Y) ? KIND_Y : KIND_OTHER;
         p_phase = PH_SPACE;
      end
   endfunction

   // one accepted character; returns 1 with the line outcome on NUL
   function bit parse_char(input logic [7:0] c, output line_outcome_t o);
      o = '0;
      if (c == CHAR_NUL) begin
         if (p_phase == PH_NUMBER) finish_number();
         else if (p_phase == PH_SPACE && p_kind != KIND_OTHER)
            flag_error(ERR_MISSING_VALUE);
         o.status = ST_SKIP;
         if (p_phase == PH_ERROR) begin
            o.status = ST_ERROR;
         end else if (!p_flags.unsup && p_flags.move && (p_flags.x || p_flags.y) &&
                      p_abs && p_mm) begin
            if (p_flags.x) p_pos_x = p_pend_x;
            if (p_flags.y) p_pos_y = p_pend_y;
            o.status = ST_MOVE;
         end
         o.err   = (o.status == ST_ERROR) ? p_err : ERR_NONE;
         o.x     = p_pos_x;
         o.y     = p_pos_y;
         p_phase = PH_BETWEEN;
         p_kind  = KIND_OTHER;
         p_flags = '0;
         p_err   = ERR_NONE;
         clear_number();
         return 1'b1;
      end
      case (p_phase)
         PH_BETWEEN: between(c);
         PH_COMMENT: if (c == CHAR_RPAREN) p_phase = PH_BETWEEN;
         PH_SPACE: begin
            // whitespace between letter and value is allowed
            if (!is_ws(c)) begin
               if (is_digit(c) || c == CHAR_POINT || c == CHAR_PLUS || c == CHAR_MINUS) begin
                  clear_number();
                  p_phase = PH_NUMBER;
                  if (c == CHAR_PLUS || c == CHAR_MINUS) p_neg = (c == CHAR_MINUS);
                  else void'(number_char(c));
               end else if (p_kind != KIND_OTHER) begin
                  flag_error(ERR_MISSING_VALUE);
               end else begin
                  // valueless other letter: this char starts the next word
                  p_phase = PH_BETWEEN;
                  between(c);
               end
            end
         end
         PH_NUMBER: begin
            if (!number_char(c)) begin
               finish_number();
               if (p_phase == PH_BETWEEN) between(c);
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Random line builder
   // ---------------------------------------------------------------------
   function void put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function void put_ws(input int max_n);
      int n;
      n = $urandom_range(0, max_n);
      repeat (n)
         line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                                 : 8'(CHAR_TAB + $urandom_range(0, 4)));
   endfunction

   function void put_letter(input logic [7:0] up);
      line_buf.push_back(($urandom_range(0, 9) < 3) ? 8'(up + CASE_OFFSET) : up);
   endfunction

   // sign, integer digits, optional point and fraction; sometimes a range edge
   function void put_number();
      int n_int, n_frac, r;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         case ($urandom_range(0, 4))
            0: put_text("214748.3647");
            1: put_text("214748.3648");
            2: put_text("-214748.3648");
            3: put_text("-214748.3649");
            default: put_text("2147483.647");
         endcase
         return;
      end
      r = $urandom_range(0, 9);
      if (r < 3) line_buf.push_back(CHAR_MINUS);
      else if (r == 3) line_buf.push_back(CHAR_PLUS);
      r = $urandom_range(0, 99);
      n_int  = (r < 70) ? $urandom_range(0, 3) : (r < 92) ? $urandom_range(4, 6)
                                                          : $urandom_range(7, 11);
      n_frac = $urandom_range(0, 1) ? $urandom_range(0, 6) : -1;
      if (n_int == 0 && n_frac <= 0 && $urandom_range(0, 4) != 0) n_int = 1;
      repeat (n_int) line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if (n_frac >= 0) begin
         line_buf.push_back(CHAR_POINT);
         repeat (n_frac) line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   // mostly well-formed move lines; some broken, some plain noise
   function void build_line();
      int shape, n_words, w, pick, cut, n;
      line_buf.delete();
      shape = $urandom_range(0, 99);
      if (shape >= 85) begin
         n = $urandom_range(1, 12);
         if ($urandom_range(0, 1)) put_letter(8'(CHAR_UP_A + $urandom_range(0, 25)));
         repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
         return;
      end
      // steer back to absolute mm most of the time so moves stay reachable
      if (!(p_abs && p_mm) && $urandom_range(0, 9) < 7) put_text("G90 G21 ");
      n_words = $urandom_range(1, 5);
      for (w = 0; w < n_words; w++) begin
         put_ws(2);
         if ($urandom_range(0, 9) == 0) begin
            line_buf.push_back(CHAR_LPAREN);
            n = $urandom_range(0, 6);
            repeat (n) line_buf.push_back(8'(CHAR_SPACE + $urandom_range(0, 8)));
            line_buf.push_back(CHAR_RPAREN);
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            put_letter(CHAR_UP_G);
            if ($urandom_range(0, 4) == 0) put_ws(2);
            case ($urandom_range(0, 6))
               0: put_text("0");
               1: put_text("1");
               2: put_text("01");
               3: put_text("1.");
               4: put_text("0.000");
               5: put_text("1.00001");
               default: put_text("00001");
            endcase
         end else if (pick < 90) begin
            put_letter(pick < 55 ? CHAR_UP_X : pick < 80 ? CHAR_UP_Y
                                                         : 8'(CHAR_UP_A + $urandom_range(0, 25)));
            if ($urandom_range(0, 4) == 0) put_ws(2);
            put_number();
         end else if (pick < 95) begin
            put_letter(CHAR_UP_G);
            case ($urandom_range(0, 7))
               0: put_text("20");
               1: put_text("91");
               2, 3, 4: put_text("21");
               default: put_text("90");
            endcase
         end else begin
            put_letter(CHAR_UP_G);
            put_number();
         end
      end
      if ($urandom_range(0, 6) == 0) begin
         line_buf.push_back(CHAR_SEMI);
         n = $urandom_range(0, 6);
         repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
      end
      // broken lines: one bad character, or cut short mid-word
      if (shape >= 70 && line_buf.size() != 0) begin
         if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 5))
               0: line_buf[pick] = CHAR_PLUS;
               1: line_buf[pick] = CHAR_MINUS;
               2: line_buf[pick] = CHAR_POINT;
               3: line_buf[pick] = CHAR_LPAREN;
               4: line_buf[pick] = 8'(CHAR_UP_A + $urandom_range(0, 25));
               default: line_buf[pick] = 8'($urandom_range(1, 255));
            endcase
         end else begin
            cut = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > cut) void'(line_buf.pop_back());
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Handshake side
   // ---------------------------------------------------------------------
   task report_mismatch(input string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   // valid stays high from word to word; it only drops for idle cycles and while draining
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender until every pending line result has come back
   task automatic drain_lines();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_outcome_q.size() != 0) @(posedge clock);
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);

   // Monitor: predict on every accepted char word, check every accepted result
   // word. Runs in the active region at the edge, so it sees pre-edge values.
   always @(posedge clock) begin : monitor
      line_outcome_t predicted;
      line_outcome_t want;
      hand_check_t   hc;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (parse_char(req_char_code, predicted)) begin
               // directed rows may carry a hand-written outcome instead
               if (hand_checked_q.size() != 0) begin
                  hc = hand_checked_q.pop_front();
                  if (hc.typed) predicted = hc.outcome;
               end
               line_outcome_q.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (line_outcome_q.size() == 0) begin
               report_mismatch("result word with no line pending");
            end else begin
               want = line_outcome_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_error_code !== want.err)
                  report_mismatch($sformatf("error_code got %0d want %0d",
                                            rsp_error_code, want.err));
               if (rsp_target_x !== want.x)
                  report_mismatch($sformatf("target_x got %0d want %0d",
                                            rsp_target_x, $signed(want.x)));
               if (rsp_target_y !== want.y)
                  report_mismatch($sformatf("target_y got %0d want %0d",
                                            rsp_target_y, $signed(want.y)));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int row, i, stage, sent, lines;
      // directed rows; positions in units of 0.0001 mm
      directed = '{
         '{"G1 X10 Y20",       1'b1, '{ST_MOVE, ERR_NONE, 32'sd100000, 32'sd200000}},
         '{"g0x-1.5y.25",      1'b1, '{ST_MOVE, ERR_NONE, -32'sd15000, 32'sd2500}},
         '{"G1 X214748.3647 Y-214748.3648", 1'b1,
           '{ST_MOVE, ERR_NONE, 32'sh7fffffff, 32'sh80000000}},
         '{"G1 X214748.3648",  1'b1,
           '{ST_ERROR, ERR_INVALID_VALUE, 32'sh7fffffff, 32'sh80000000}},
         '{"G1 X-214748.36489", 1'b1, '{ST_MOVE, ERR_NONE, 32'sh80000000, 32'sh80000000}},
         '{"G1 X1 (note 5) Y 2 ; X9", 1'b1, '{ST_MOVE, ERR_NONE, 32'sd10000, 32'sd20000}},
         '{"G1 5",             1'b1, '{ST_ERROR, ERR_EXPECTED_WORD, 32'sd10000, 32'sd20000}},
         '{"G1 X",             1'b1, '{ST_ERROR, ERR_MISSING_VALUE, 32'sd10000, 32'sd20000}},
         '{"G1 X-",            1'b1, '{ST_ERROR, ERR_MISSING_VALUE, 32'sd10000, 32'sd20000}},
         '{"F Y3 G1",          1'b1, '{ST_MOVE, ERR_NONE, 32'sd10000, 32'sd30000}},
         '{"F- X1 G1",         1'b1, '{ST_ERROR, ERR_EXPECTED_WORD, 32'sd10000, 32'sd30000}},
         '{"G1.5 X1",          1'b1, '{ST_ERROR, ERR_INVALID_G, 32'sd10000, 32'sd30000}},
         '{"G-1 X1",           1'b1, '{ST_SKIP, ERR_NONE, 32'sd10000, 32'sd30000}},
         '{"G-0 X7",           1'b1, '{ST_MOVE, ERR_NONE, 32'sd70000, 32'sd30000}},
         '{"G1 X1.2.3",        1'b1, '{ST_ERROR, ERR_EXPECTED_WORD, 32'sd70000, 32'sd30000}},
         '{"G1 X1-2",          1'b1, '{ST_ERROR, ERR_EXPECTED_WORD, 32'sd70000, 32'sd30000}},
         // from here on the predictor supplies the outcome
         '{"G1 X2e5",                1'b0, '0},
         '{"G91 G1 X1",              1'b0, '0},
         '{"G1 X1 ?",                1'b0, '0},
         '{"G90 G20 G1 X1",          1'b0, '0},
         '{"G21 G1 Y1 Z99999999999", 1'b0, '0},
         '{"G2 X5 Y5",               1'b0, '0},
         '{"G1",                     1'b0, '0},
         '{"",                       1'b0, '0},
         '{"G 1 X\t3",               1'b0, '0},
         '{"G99999999 X1",           1'b0, '0},
         '{"G1 Y9999999999",         1'b0, '0},
         '{"G01.00001 x-0",          1'b0, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, under the first idle mix
      for (row = 0; row < N_DIRECTED; row++) begin
         hand_checked_q.push_back('{directed[row].typed, directed[row].outcome});
         for (i = 0; i < directed[row].text.len(); i++) send_char(directed[row].text[i]);
         send_char(CHAR_NUL);
      end

      // random part in three idle mixes; each ends with a full drain
      for (stage = 0; stage < 3; stage++) begin
         case (stage)
            0:       begin tx_idle_pct = 9;  rx_idle_pct = 49; end
            1:       begin tx_idle_pct = 49; rx_idle_pct = 9;  end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         sent  = 0;
         lines = 0;
         while (sent < 200 || lines < 14) begin
            build_line();
            for (i = 0; i < line_buf.size(); i++) send_char(line_buf[i]);
            send_char(CHAR_NUL);
            sent  += line_buf.size() + 1;
            lines++;
         end
         drain_lines();
      end

      // wait out any stray result word
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("gcode_line_move_parser verification clean");
      else
         $display("gcode_line_move_parser verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("gcode_line_move_parser verification failed");
      $finish;
   end

endmodule
